/* rtl/versioned_slot_allocator_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the versioned slot allocator
// Define ASSERT_OFF to compile the checks out.
// ----------------------------------------------------------------------------
`ifndef VERSIONED_SLOT_ALLOCATOR_TOP_MACROS_SVH
`define VERSIONED_SLOT_ALLOCATOR_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Condition must never hold outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("assertion failed: condition must never hold");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: implication violated");

`else

`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/vsa_pkg.sv */
// ----------------------------------------------------------------------------
// vsa_pkg
// Types, widths and codes of the versioned slot allocator.
// ----------------------------------------------------------------------------
package vsa_pkg;

    localparam int POOL_SLOTS = 256;
    localparam int SLOT_W     = $clog2(POOL_SLOTS);
    localparam int CNT_W      = SLOT_W + 1;
    localparam int VER_W      = 16;
    localparam int STRIDE_W   = 16;
    localparam int OFFS_W     = 24;
    localparam int CFG_DATA_W = 16;

    typedef logic [1:0] t_op;
    typedef logic [2:0] t_status;
    typedef logic       t_cfg_idx;

    localparam t_op OP_ALLOC   = 2'd0;
    localparam t_op OP_LOOKUP  = 2'd1;
    localparam t_op OP_RELEASE = 2'd2;
    localparam t_op OP_NONE    = 2'd3;

    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_EMPTY     = 3'd1;
    localparam t_status ST_NOT_ALLOC = 3'd2;
    localparam t_status ST_MISMATCH  = 3'd3;
    localparam t_status ST_RANGE     = 3'd4;

    localparam t_cfg_idx CFG_SLOT_STRIDE = 1'b0;
    localparam t_cfg_idx CFG_SLOT_COUNT  = 1'b1;

    localparam logic [STRIDE_W-1:0] STRIDE_RST = 16'd1;
    localparam logic [CNT_W-1:0]    COUNT_RST  = 9'd256;

    // Request as it sits in the second stage.
    typedef struct packed {
        t_op               op;
        t_status           status;
        logic [SLOT_W-1:0] idx;
        logic [SLOT_W-1:0] slot;
        logic [VER_W-1:0]  ver;
    } t_stage_b;

endpackage

/* rtl/versioned_slot_allocator_top.sv */
// ----------------------------------------------------------------------------
// versioned_slot_allocator_top: 3 stages (request, generation, result)
// Result: an input beat passes the stage A, B and C registers; one beat per cycle
// while the output does not stall. Generation memory read, write-back and forwarding.
// Sync reset clears marks, generation valid bits, queue and fresh pointers.
// ----------------------------------------------------------------------------
`include "versioned_slot_allocator_top_macros.svh"

module versioned_slot_allocator_top
    import vsa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_op                   i_operation,
    input  logic [SLOT_W-1:0]     i_slot_index,
    input  logic [VER_W-1:0]      i_slot_version,

    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_status               o_status,
    output logic [SLOT_W-1:0]     o_granted_index,
    output logic [VER_W-1:0]      o_granted_version,
    output logic [OFFS_W-1:0]     o_byte_offset,

    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    // configuration
    logic [STRIDE_W-1:0] r_cfg_stride;
    logic [CNT_W-1:0]    r_cfg_count;

    // slot state
    logic [POOL_SLOTS-1:0] r_mark;
    logic [POOL_SLOTS-1:0] r_gen_vld;
    logic [VER_W-1:0]      r_gen_mem [POOL_SLOTS];
    logic [SLOT_W-1:0]     r_q_mem   [POOL_SLOTS];
    logic [SLOT_W-1:0]     r_q_front;
    logic [SLOT_W-1:0]     r_q_head, n_q_head;
    logic [CNT_W-1:0]      r_q_fill, n_q_fill;
    logic [CNT_W-1:0]      r_fresh,  n_fresh;

    // stage A
    logic              r_a_valid;
    t_op               r_a_op;
    logic [SLOT_W-1:0] r_a_idx;
    logic [VER_W-1:0]  r_a_ver;

    // stage B
    logic              r_b_valid;
    t_stage_b          r_b;
    logic [VER_W-1:0]  r_b_rd;
    logic              r_b_gvld;
    logic              r_b_fwd;
    logic [VER_W-1:0]  r_b_fwd_gen;

    // stage C
    logic              r_c_valid;
    t_status           r_c_status;
    logic [SLOT_W-1:0] r_c_gidx;
    logic [VER_W-1:0]  r_c_gver;
    logic [OFFS_W-1:0] r_c_offs;

    // flow control
    logic ready_a, ready_b, ready_c;
    logic in_acc, adv_ab, adv_bc;

    // stage A logic
    logic [CNT_W-1:0]  live;
    logic              a_range;
    t_status           a_status;
    logic [SLOT_W-1:0] a_slot;
    logic              a_pop, a_fresh, a_set, a_clr, a_push;
    logic [CNT_W-1:0]  tail_sum;
    logic [SLOT_W-1:0] q_tail;
    logic              q_we;

    // stage B logic
    logic                       b_alloc_ok;
    logic                       b_we;
    logic [VER_W-1:0]           b_gen;
    logic [VER_W-1:0]           b_new_gen;
    t_status                    b_status;
    logic [SLOT_W+STRIDE_W-1:0] b_prod;

    assign ready_c    = !r_c_valid || !i_out_stall;
    assign adv_bc     = r_b_valid && ready_c;
    assign ready_b    = !r_b_valid || ready_c;
    assign adv_ab     = r_a_valid && ready_b;
    assign ready_a    = !r_a_valid || ready_b;
    assign in_acc     = i_in_valid && ready_a;
    assign o_in_stall = !ready_a;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_stride <= STRIDE_RST;
            r_cfg_count  <= COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SLOT_STRIDE: r_cfg_stride <= i_cfg_wdata[STRIDE_W-1:0];
                CFG_SLOT_COUNT:  r_cfg_count  <= i_cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage A: pick the slot, check range and mark
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_acc) begin
            // drop unused operation codes here
            r_a_valid <= (i_operation != OP_NONE);
        end else if (adv_ab) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_op  <= i_operation;
            r_a_idx <= i_slot_index;
            r_a_ver <= i_slot_version;
        end
    end

    assign live    = (r_cfg_count > CNT_W'(POOL_SLOTS)) ? CNT_W'(POOL_SLOTS) : r_cfg_count;
    assign a_range = ({1'b0, r_a_idx} >= live);

    always_comb begin
        a_status = ST_OK;
        a_slot   = r_a_idx;
        a_pop    = 1'b0;
        a_fresh  = 1'b0;
        a_set    = 1'b0;
        a_clr    = 1'b0;
        a_push   = 1'b0;
        unique case (r_a_op)
            OP_ALLOC: begin
                priority if (r_q_fill != '0) begin
                    a_slot = r_q_front;
                    a_pop  = 1'b1;
                    a_set  = 1'b1;
                end else if (r_fresh < live) begin
                    a_slot  = r_fresh[SLOT_W-1:0];
                    a_fresh = 1'b1;
                    a_set   = 1'b1;
                end else begin
                    a_status = ST_EMPTY;
                end
            end
            OP_LOOKUP: begin
                priority if (a_range) begin
                    a_status = ST_RANGE;
                end else if (!r_mark[r_a_idx]) begin
                    a_status = ST_NOT_ALLOC;
                end
            end
            OP_RELEASE: begin
                priority if (a_range) begin
                    a_status = ST_RANGE;
                end else if (!r_mark[r_a_idx]) begin
                    a_status = ST_NOT_ALLOC;
                end else begin
                    a_clr  = 1'b1;
                    a_push = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // queue pointers
    assign tail_sum = {1'b0, r_q_head} + r_q_fill;
    assign q_tail   = (tail_sum >= CNT_W'(POOL_SLOTS))
                    ? SLOT_W'(tail_sum - CNT_W'(POOL_SLOTS))
                    : SLOT_W'(tail_sum);
    assign q_we     = adv_ab && a_push && (r_q_fill < CNT_W'(POOL_SLOTS));

    always_comb begin
        n_q_head = r_q_head;
        n_q_fill = r_q_fill;
        n_fresh  = r_fresh;
        if (adv_ab && a_pop) begin
            n_q_head = (r_q_head == SLOT_W'(POOL_SLOTS - 1)) ? '0 : r_q_head + 1'b1;
            n_q_fill = r_q_fill - 1'b1;
        end
        if (q_we) begin
            n_q_fill = r_q_fill + 1'b1;
        end
        if (adv_ab && a_fresh) begin
            n_fresh = r_fresh + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_head <= '0;
            r_q_fill <= '0;
            r_fresh  <= '0;
        end else begin
            r_q_head <= n_q_head;
            r_q_fill <= n_q_fill;
            r_fresh  <= n_fresh;
        end
    end

    // free queue; keep the entry at the next head prefetched
    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_q_mem[q_tail] <= r_a_idx;
        end
        r_q_front <= (q_we && q_tail == n_q_head) ? r_a_idx : r_q_mem[n_q_head];
    end

    // allocated marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark <= '0;
        end else if (adv_ab && a_set) begin
            r_mark[a_slot] <= 1'b1;
        end else if (adv_ab && a_clr) begin
            r_mark[a_slot] <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // stage B: generation read-modify-write, version compare, offset
    // ------------------------------------------------------------------
    assign b_alloc_ok = (r_b.op == OP_ALLOC) && (r_b.status == ST_OK);
    assign b_we       = adv_bc && b_alloc_ok;
    assign b_gen      = r_b_fwd ? r_b_fwd_gen : (r_b_gvld ? r_b_rd : '0);
    assign b_new_gen  = b_gen + 1'b1;
    assign b_prod     = r_b.idx * r_cfg_stride;

    always_comb begin
        b_status = r_b.status;
        if (r_b.op == OP_LOOKUP && r_b.status == ST_OK && b_gen != r_b.ver) begin
            b_status = ST_MISMATCH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_we) begin
            r_gen_mem[r_b.slot] <= b_new_gen;
        end
        if (adv_ab) begin
            r_b_rd <= r_gen_mem[a_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen_vld <= '0;
        end else if (b_we) begin
            r_gen_vld[r_b.slot] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (adv_ab) begin
            r_b_valid <= 1'b1;
        end else if (adv_bc) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_ab) begin
            r_b.op      <= r_a_op;
            r_b.status  <= a_status;
            r_b.idx     <= r_a_idx;
            r_b.slot    <= a_slot;
            r_b.ver     <= r_a_ver;
            r_b_gvld    <= r_gen_vld[a_slot];
            // forward the generation written at this same edge
            r_b_fwd     <= b_we && (r_b.slot == a_slot);
            r_b_fwd_gen <= b_new_gen;
        end
    end

    // ------------------------------------------------------------------
    // stage C: result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (adv_bc) begin
            r_c_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_c_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_bc) begin
            r_c_status <= b_status;
            r_c_gidx   <= b_alloc_ok ? r_b.slot : r_b.idx;
            r_c_gver   <= b_alloc_ok ? b_new_gen : '0;
            r_c_offs   <= (r_b.op == OP_LOOKUP && b_status == ST_OK)
                        ? OFFS_W'(b_prod) : '0;
        end
    end

    assign o_out_valid       = r_c_valid;
    assign o_status          = r_c_status;
    assign o_granted_index   = r_c_gidx;
    assign o_granted_version = r_c_gver;
    assign o_byte_offset     = r_c_offs;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `ASSERT_NEVER(a_fill_bound, i_clk, i_rst_n, r_q_fill > CNT_W'(POOL_SLOTS))
    `ASSERT_NEVER(a_fresh_bound, i_clk, i_rst_n, r_fresh > CNT_W'(POOL_SLOTS))
    `ASSERT_IMPLY(a_pop_slot_free, i_clk, i_rst_n, adv_ab && a_pop, !r_mark[r_q_front])

endmodule

/* test/tb_versioned_slot_allocator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_versioned_slot_allocator_top
// Self-checking bench for the versioned slot allocator. Allocate, lookup and
// release requests go in with random gaps and output stalls. A scoreboard
// tracks marks, generations, the free queue and the fresh pointer, predicts
// every reply and compares it field by field.
// ----------------------------------------------------------------------------
module tb_versioned_slot_allocator_top;
    import vsa_pkg::*;

    localparam int HOLD_CYCLES = 4;
    localparam int STUCK_LIMIT = 2000;
    localparam int PHASE_ITEMS = 180;
    localparam int CHURN_ITEMS = 80;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] index;
        logic [VER_W-1:0]  version;
        logic [OFFS_W-1:0] offset;
    } t_slot_reply;

    class slot_pool_scoreboard;
        bit                  in_use[POOL_SLOTS];
        logic [VER_W-1:0]    generation[POOL_SLOTS];
        logic [SLOT_W-1:0]   recycled[$];
        int unsigned         fresh_next;
        logic [STRIDE_W-1:0] stride;
        logic [CNT_W-1:0]    count_reg;
        t_slot_reply         awaited[$];
        int unsigned         errors;
        int unsigned         requests;
        int unsigned         by_status[5];

        function void clear();
            foreach (in_use[i]) begin
                in_use[i]     = 1'b0;
                generation[i] = '0;
            end
            foreach (by_status[i]) by_status[i] = 0;
            recycled.delete();
            awaited.delete();
            fresh_next = 0;
            stride     = STRIDE_RST;
            count_reg  = COUNT_RST;
            errors     = 0;
            requests   = 0;
        endfunction

        function void set_register(t_cfg_idx which, logic [CFG_DATA_W-1:0] data);
            if (which == CFG_SLOT_STRIDE)
                stride = data[STRIDE_W-1:0];
            else
                count_reg = data[CNT_W-1:0];
        endfunction

        // counts above the pool size saturate
        function int unsigned live_count();
            return (count_reg > POOL_SLOTS) ? POOL_SLOTS : int'(count_reg);
        endfunction

        function int pick_live();
            int found[$];
            for (int i = 0; i < live_count(); i++)
                if (in_use[i]) found.push_back(i);
            if (found.size() == 0) return -1;
            return found[$urandom_range(0, found.size() - 1)];
        endfunction

        function void predict_reply(t_op op, logic [SLOT_W-1:0] idx, logic [VER_W-1:0] ver);
            t_slot_reply r;
            int unsigned slot;
            int unsigned prod;
            bit          got;
            if (op == OP_NONE) return;
            r.status  = ST_OK;
            r.index   = idx;
            r.version = '0;
            r.offset  = '0;
            got       = 1'b0;
            slot      = 0;
            if (op == OP_ALLOC) begin
                // recycled slots first, oldest release wins
                if (recycled.size() != 0) begin
                    slot = 32'(recycled.pop_front());
                    got  = 1'b1;
                end else if (fresh_next < live_count()) begin
                    slot = fresh_next;
                    fresh_next++;
                    got  = 1'b1;
                end
                if (!got) begin
                    r.status = ST_EMPTY;
                end else begin
                    in_use[slot]     = 1'b1;
                    generation[slot] = generation[slot] + 1'b1;
                    r.index          = slot[SLOT_W-1:0];
                    r.version        = generation[slot];
                end
            end else if (idx >= live_count()) begin
                r.status = ST_RANGE;
            end else if (op == OP_LOOKUP) begin
                if (!in_use[idx]) begin
                    r.status = ST_NOT_ALLOC;
                end else if (generation[idx] != ver) begin
                    r.status = ST_MISMATCH;
                end else begin
                    prod     = 32'(idx) * 32'(stride);
                    r.offset = prod[OFFS_W-1:0];
                end
            end else begin
                if (!in_use[idx]) begin
                    r.status = ST_NOT_ALLOC;
                end else begin
                    in_use[idx] = 1'b0;
                    if (recycled.size() < POOL_SLOTS) recycled.push_back(idx);
                end
            end
            requests++;
            awaited.push_back(r);
        endfunction

        task report(string msg);
            $display("%0t: mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_reply(t_status st, logic [SLOT_W-1:0] gi, logic [VER_W-1:0] gv,
                         logic [OFFS_W-1:0] off);
            t_slot_reply want;
            if (awaited.size() == 0) begin
                report($sformatf("reply with no request pending, status %0d", st));
                return;
            end
            want = awaited.pop_front();
            by_status[want.status]++;
            if (st !== want.status)
                report($sformatf("status got %0d expected %0d", st, want.status));
            if (gi !== want.index)
                report($sformatf("granted_index got %0d expected %0d", gi, want.index));
            if (gv !== want.version)
                report($sformatf("granted_version got %0h expected %0h", gv, want.version));
            if (off !== want.offset)
                report($sformatf("byte_offset got %0h expected %0h", off, want.offset));
        endtask
    endclass

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_stall;
    t_op                   i_operation    = OP_NONE;
    logic [SLOT_W-1:0]     i_slot_index   = '0;
    logic [VER_W-1:0]      i_slot_version = '0;
    logic                  o_out_valid;
    logic                  i_out_stall    = 1'b0;
    t_status               o_status;
    logic [SLOT_W-1:0]     o_granted_index;
    logic [VER_W-1:0]      o_granted_version;
    logic [OFFS_W-1:0]     o_byte_offset;
    logic                  i_cfg_we       = 1'b0;
    t_cfg_idx              i_cfg_idx      = CFG_SLOT_STRIDE;
    logic [CFG_DATA_W-1:0] i_cfg_wdata    = '0;

    slot_pool_scoreboard pool;
    int unsigned         stuck_cycles  = 0;
    int unsigned         settings_seen = 0;
    bit                  steady        = 1'b0;

    versioned_slot_allocator_top dut (.*);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // receiver side backpressure
    always @(negedge i_clk) i_out_stall <= !steady && ($urandom_range(0, 99) < 12);

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                pool.predict_reply(i_operation, i_slot_index, i_slot_version);
            if (o_out_valid && !i_out_stall)
                pool.check_reply(o_status, o_granted_index, o_granted_version, o_byte_offset);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
    end

    initial begin
        wait (stuck_cycles >= STUCK_LIMIT);
        $display("watchdog: no beat moved for %0d cycles", STUCK_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // call at a falling edge; returns at the rising edge that takes the beat
    task automatic issue(t_op op, logic [SLOT_W-1:0] idx, logic [VER_W-1:0] ver);
        i_in_valid     <= 1'b1;
        i_operation    <= op;
        i_slot_index   <= idx;
        i_slot_version <= ver;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic put(t_op op, logic [SLOT_W-1:0] idx, logic [VER_W-1:0] ver);
        @(negedge i_clk);
        issue(op, idx, ver);
    endtask

    task automatic pause_sender(int unsigned n);
        repeat (n) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
    endtask

    // hold off until every reply is back, then let dropped requests flush
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pool.awaited.size() != 0) @(posedge i_clk);
        repeat (HOLD_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx which, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= which;
        i_cfg_wdata <= data;
        pool.set_register(which, data);
        @(posedge i_clk);
    endtask

    task automatic reconfigure(logic [CFG_DATA_W-1:0] stride, logic [CFG_DATA_W-1:0] count);
        settle();
        cfg_write(CFG_SLOT_STRIDE, stride);
        cfg_write(CFG_SLOT_COUNT, count);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings_seen++;
    endtask

    task automatic next_item(bit churn);
        t_op               op;
        logic [SLOT_W-1:0] idx;
        logic [VER_W-1:0]  ver;
        int                live;
        int unsigned       roll;
        int unsigned       shade;
        if (!steady && $urandom_range(0, 99) < 6) pause_sender($urandom_range(1, 3));
        @(negedge i_clk);
        idx   = SLOT_W'($urandom);
        ver   = VER_W'($urandom);
        roll  = $urandom_range(0, 99);
        shade = $urandom_range(0, 99);
        live  = pool.pick_live();
        if (roll < 3)
            op = OP_NONE;
        else if (churn && pool.in_use[0])
            op = (roll < 80) ? OP_RELEASE : OP_LOOKUP;
        else if (churn)
            op = (roll < 88) ? OP_ALLOC : OP_RELEASE;
        else if (roll < 40)
            op = OP_ALLOC;
        else if (roll < 70)
            op = OP_LOOKUP;
        else
            op = OP_RELEASE;
        // aim most lookups and releases at a live slot
        if (live >= 0 && op == OP_LOOKUP && shade < 87) begin
            idx = live[SLOT_W-1:0];
            ver = pool.generation[live];
            if (shade >= 75) ver[$urandom_range(0, VER_W - 1)] ^= 1'b1;
        end else if (live >= 0 && op == OP_RELEASE && shade < 80) begin
            idx = live[SLOT_W-1:0];
        end
        issue(op, idx, ver);
    endtask

    initial begin
        pool = new();
        pool.clear();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // fresh pool, reset register values
        put(OP_LOOKUP,  8'd0,   16'd0);
        put(OP_RELEASE, 8'd0,   16'd0);
        put(OP_NONE,    8'hFF,  16'hFFFF);
        put(OP_ALLOC,   8'hFF,  16'hFFFF);
        put(OP_ALLOC,   8'd0,   16'd0);
        put(OP_LOOKUP,  8'd0,   16'd1);
        put(OP_LOOKUP,  8'd1,   16'd2);
        put(OP_LOOKUP,  8'd1,   16'd1);
        put(OP_RELEASE, 8'd0,   16'd0);
        put(OP_RELEASE, 8'd0,   16'd0);
        put(OP_ALLOC,   8'd0,   16'd0);
        put(OP_RELEASE, 8'd1,   16'd0);
        put(OP_ALLOC,   8'd0,   16'd0);
        put(OP_LOOKUP,  8'hFF,  16'hFFFF);

        // lower the count to one above the fresh pointer, widest stride
        reconfigure(16'hFFFF, 16'd3);
        put(OP_ALLOC,   8'd0,   16'd0);
        put(OP_ALLOC,   8'h55,  16'hAAAA);
        put(OP_LOOKUP,  8'd2,   16'd1);
        put(OP_LOOKUP,  8'd3,   16'd1);
        put(OP_RELEASE, 8'hFF,  16'd0);

        // zero slots: everything is out of range or empty
        reconfigure(16'd1, 16'd0);
        put(OP_ALLOC,   8'd0,   16'd0);
        put(OP_LOOKUP,  8'd0,   16'd2);

        // count above the pool saturates
        reconfigure(16'd7, 16'd511);
        put(OP_LOOKUP,  8'hFF,  16'hFFFF);
        put(OP_RELEASE, 8'd2,   16'd0);
        put(OP_ALLOC,   8'd0,   16'd0);

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: reconfigure(16'hFFFF, 16'd256);
                1: reconfigure(16'd1, 16'd1);
                2: reconfigure(CFG_DATA_W'($urandom_range(1, 65535)),
                               CFG_DATA_W'($urandom_range(2, 16)));
                3: reconfigure(CFG_DATA_W'($urandom_range(1, 65535)),
                               CFG_DATA_W'($urandom_range(17, 256)));
                4: reconfigure(CFG_DATA_W'($urandom_range(1, 65535)),
                               CFG_DATA_W'($urandom_range(300, 511)));
                default: reconfigure(CFG_DATA_W'($urandom_range(1, 65535)),
                                     CFG_DATA_W'($urandom_range(1, 8)));
            endcase
            steady = (p == 3);
            repeat (PHASE_ITEMS) next_item(1'b0);
        end
        steady = 1'b0;

        // single slot churn: allocate, release and look up slot 0
        reconfigure(CFG_DATA_W'($urandom_range(1, 65535)), 16'd1);
        repeat (CHURN_ITEMS) next_item(1'b1);
        settle();

        $display("Covered %0d requests over %0d register settings, ending with slot 0 churn.",
                 pool.requests, settings_seen);
        $display("Replies: ok %0d, empty %0d, not allocated %0d, stale %0d, out of range %0d.",
                 pool.by_status[ST_OK], pool.by_status[ST_EMPTY], pool.by_status[ST_NOT_ALLOC],
                 pool.by_status[ST_MISMATCH], pool.by_status[ST_RANGE]);
        if (pool.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
